// ===== src/ktl_pkg.sv =====
package ktl_pkg;

   localparam int DEFAULT_TEXT_BUFFER_SIZE = 64;
   localparam int MAX_RESULTS = 3;
   localparam int QUEUE_DEPTH = 4;
   localparam int KEYWORD_COUNT = 16;

   typedef enum logic [2:0] {
      MODE_IDLE   = 3'd0,
      MODE_MINUS  = 3'd1,
      MODE_COLON  = 3'd2,
      MODE_MEMREF = 3'd3,
      MODE_NUMBER = 3'd4,
      MODE_IDENT  = 3'd5
   } mode_type;

   localparam logic [4:0] KIND_UNKNOWN  = 5'd0;
   localparam logic [4:0] KIND_EOF      = 5'd1;
   localparam logic [4:0] KIND_LPAREN   = 5'd2;
   localparam logic [4:0] KIND_RPAREN   = 5'd3;
   localparam logic [4:0] KIND_SEMI     = 5'd4;
   localparam logic [4:0] KIND_COMMA    = 5'd5;
   localparam logic [4:0] KIND_PLUS     = 5'd6;
   localparam logic [4:0] KIND_PERCENT  = 5'd7;
   localparam logic [4:0] KIND_DOT      = 5'd8;
   localparam logic [4:0] KIND_ARROW    = 5'd9;
   localparam logic [4:0] KIND_ASSIGN   = 5'd10;
   localparam logic [4:0] KIND_MEMREF   = 5'd11;
   localparam logic [4:0] KIND_NUMBER   = 5'd12;
   localparam logic [4:0] KIND_IDENT    = 5'd13;
   localparam logic [4:0] KIND_KEYWORD0 = 5'd14;

   // keyword text right-aligned, first character in the highest used byte
   localparam logic [63:0] KW_TEXT [KEYWORD_COUNT] = '{
      64'("zone"), 64'("mem"), 64'("emit"), 64'("split"),
      64'("move"), 64'("store"), 64'("retrieve"), 64'("cycle"),
      64'("fuse"), 64'("on"), 64'("empty"), 64'("not"),
      64'("if"), 64'("every"), 64'("ms"), 64'("all")
   };

   localparam logic [3:0] KW_LEN [KEYWORD_COUNT] = '{
      4'd4, 4'd3, 4'd4, 4'd5, 4'd4, 4'd5, 4'd8, 4'd5,
      4'd4, 4'd2, 4'd5, 4'd3, 4'd2, 4'd5, 4'd2, 4'd3
   };

   typedef struct packed {
      logic [4:0]  kind;
      logic [15:0] line;
      logic [15:0] column;
      logic [31:0] offset;
      logic [15:0] length;
      logic        dropped;
      logic        last;
   } token_rec_type;

endpackage

// ===== src/ktl_scan.sv =====
module ktl_scan import ktl_pkg::*; #(
   parameter int TEXT_BUFFER_SIZE = DEFAULT_TEXT_BUFFER_SIZE
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          accept,
   input  logic [7:0]    text_byte,
   input  logic          final_byte,
   output logic [1:0]    push_count,
   output token_rec_type push_rec [MAX_RESULTS]
);

   localparam logic [7:0] CH_LPAREN  = "(";
   localparam logic [7:0] CH_RPAREN  = ")";
   localparam logic [7:0] CH_SEMI    = ";";
   localparam logic [7:0] CH_COMMA   = ",";
   localparam logic [7:0] CH_PLUS    = "+";
   localparam logic [7:0] CH_PERCENT = "%";
   localparam logic [7:0] CH_DOT     = ".";
   localparam logic [7:0] CH_MINUS   = "-";
   localparam logic [7:0] CH_GREATER = ">";
   localparam logic [7:0] CH_COLON   = ":";
   localparam logic [7:0] CH_EQUAL   = "=";
   localparam logic [7:0] CH_HASH    = "#";
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_SPACE   = " ";
   localparam logic [7:0] CH_UNDER   = "_";
   localparam logic [15:0] DROP_LEN  = 16'(TEXT_BUFFER_SIZE);

   mode_type    mode_ff, mode_in;
   logic [63:0] win_ff, win_in;
   logic [15:0] rlen_ff, rlen_in;
   logic [15:0] sline_ff, sline_in;
   logic [15:0] scol_ff, scol_in;
   logic [31:0] soff_ff, soff_in;
   logic [15:0] cline_ff, cline_in;
   logic [15:0] ccol_ff, ccol_in;
   logic [31:0] coff_ff, coff_in;

   function automatic logic is_digit(input logic [7:0] b);
      return b >= "0" && b <= "9";
   endfunction

   function automatic logic is_ident(input logic [7:0] b);
      return is_digit(b) || (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == CH_UNDER;
   endfunction

   function automatic logic is_space(input logic [7:0] b);
      return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
   endfunction

   function automatic logic [15:0] inc16(input logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

   function automatic logic [31:0] inc32(input logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
   endfunction

   function automatic logic [4:0] single_kind(input logic [7:0] b);
      logic [4:0] k;
      case (b)
         CH_LPAREN:  k = KIND_LPAREN;
         CH_RPAREN:  k = KIND_RPAREN;
         CH_SEMI:    k = KIND_SEMI;
         CH_COMMA:   k = KIND_COMMA;
         CH_PLUS:    k = KIND_PLUS;
         CH_PERCENT: k = KIND_PERCENT;
         CH_DOT:     k = KIND_DOT;
         default:    k = KIND_UNKNOWN;
      endcase
      return k;
   endfunction

   // sixteen independent compares, first match wins
   function automatic logic [4:0] keyword_kind(input logic [63:0] win, input logic [15:0] rlen);
      logic [4:0]  k;
      logic [63:0] mask;
      k = KIND_IDENT;
      for (int i = KEYWORD_COUNT - 1; i >= 0; i--) begin
         mask = (KW_LEN[i] >= 4'd8) ? '1 : ((64'd1 << {KW_LEN[i], 3'b000}) - 64'd1);
         if (rlen == {12'd0, KW_LEN[i]} && (win & mask) == KW_TEXT[i]) begin
            k = KIND_KEYWORD0 + 5'(i);
         end
      end
      return k;
   endfunction

   function automatic token_rec_type make_rec(
      input logic [4:0]  kind,
      input logic [15:0] line,
      input logic [15:0] column,
      input logic [31:0] offset,
      input logic [15:0] length,
      input logic        dropped
   );
      token_rec_type r;
      r.kind    = kind;
      r.line    = line;
      r.column  = column;
      r.offset  = offset;
      r.length  = length;
      r.dropped = dropped;
      r.last    = 1'b0;
      return r;
   endfunction

   // token left pending in the given mode
   function automatic token_rec_type flush_rec(
      input mode_type    md,
      input logic [63:0] win,
      input logic [15:0] rlen,
      input logic [15:0] line,
      input logic [15:0] column,
      input logic [31:0] offset
   );
      logic          drop;
      token_rec_type r;
      drop = rlen >= DROP_LEN;
      case (md)
         MODE_MEMREF: r = make_rec(KIND_MEMREF, line, column, offset, rlen, drop);
         MODE_NUMBER: r = make_rec(KIND_NUMBER, line, column, offset, rlen, drop);
         MODE_IDENT:  r = make_rec(drop ? KIND_IDENT : keyword_kind(win, rlen),
                                   line, column, offset, rlen, drop);
         default:     r = make_rec(KIND_UNKNOWN, line, column, offset, 16'd1, 1'b0);
      endcase
      return r;
   endfunction

   token_rec_type rec_a, rec_b, rec_c, rec_d;
   logic          ok_a, ok_b, ok_c, ok_d;
   logic          used;
   logic [1:0]    n;

   always_comb begin
      mode_in  = mode_ff;
      win_in   = win_ff;
      rlen_in  = rlen_ff;
      sline_in = sline_ff;
      scol_in  = scol_ff;
      soff_in  = soff_ff;
      cline_in = cline_ff;
      ccol_in  = ccol_ff;
      coff_in  = coff_ff;
      used     = 1'b0;
      rec_a    = '0;
      rec_b    = '0;
      rec_c    = '0;
      rec_d    = '0;
      ok_a     = 1'b0;
      ok_b     = 1'b0;
      ok_c     = 1'b0;
      ok_d     = 1'b0;

      // continue or close the pending token
      case (mode_ff)
         MODE_MINUS, MODE_COLON: begin
            ok_a    = 1'b1;
            mode_in = MODE_IDLE;
            if ((mode_ff == MODE_MINUS && text_byte == CH_GREATER) ||
                (mode_ff == MODE_COLON && text_byte == CH_EQUAL)) begin
               rec_a = make_rec((mode_ff == MODE_MINUS) ? KIND_ARROW : KIND_ASSIGN,
                                sline_ff, scol_ff, soff_ff, 16'd2, 1'b0);
               used  = 1'b1;
            end else begin
               rec_a   = flush_rec(mode_ff, win_ff, rlen_ff, sline_ff, scol_ff, soff_ff);
               rlen_in = '0;
               win_in  = '0;
            end
         end
         MODE_MEMREF, MODE_IDENT, MODE_NUMBER: begin
            if ((mode_ff == MODE_NUMBER) ? is_digit(text_byte) : is_ident(text_byte)) begin
               rlen_in = inc16(rlen_ff);
               win_in  = {win_ff[55:0], text_byte};
               used    = 1'b1;
            end else begin
               ok_a    = 1'b1;
               rec_a   = flush_rec(mode_ff, win_ff, rlen_ff, sline_ff, scol_ff, soff_ff);
               mode_in = MODE_IDLE;
               rlen_in = '0;
               win_in  = '0;
            end
         end
         default: ;
      endcase

      // byte not taken by a pending token
      if (!used && !is_space(text_byte)) begin
         if (single_kind(text_byte) != KIND_UNKNOWN) begin
            ok_b  = 1'b1;
            rec_b = make_rec(single_kind(text_byte), cline_ff, ccol_ff, coff_ff, 16'd1, 1'b0);
         end else if (text_byte == CH_MINUS || text_byte == CH_COLON || text_byte == CH_HASH ||
                      is_ident(text_byte)) begin
            sline_in = cline_ff;
            scol_in  = ccol_ff;
            soff_in  = coff_ff;
            rlen_in  = '0;
            win_in   = '0;
            if (text_byte == CH_MINUS) begin
               mode_in = MODE_MINUS;
            end else if (text_byte == CH_COLON) begin
               mode_in = MODE_COLON;
            end else if (text_byte == CH_HASH) begin
               mode_in = MODE_MEMREF;
               rlen_in = 16'd1;
            end else begin
               mode_in = is_digit(text_byte) ? MODE_NUMBER : MODE_IDENT;
               rlen_in = 16'd1;
               win_in  = {56'd0, text_byte};
            end
         end else begin
            ok_b  = 1'b1;
            rec_b = make_rec(KIND_UNKNOWN, cline_ff, ccol_ff, coff_ff, 16'd1, 1'b0);
         end
      end

      if (text_byte == CH_NEWLINE) begin
         cline_in = inc16(cline_ff);
         ccol_in  = 16'd1;
      end else begin
         ccol_in  = inc16(ccol_ff);
      end
      coff_in = inc32(coff_ff);

      // end of text: flush, end-of-input, back to the reset state
      if (final_byte) begin
         ok_c     = mode_in != MODE_IDLE;
         rec_c    = flush_rec(mode_in, win_in, rlen_in, sline_in, scol_in, soff_in);
         ok_d     = 1'b1;
         rec_d    = make_rec(KIND_EOF, cline_in, ccol_in, coff_in, 16'd0, 1'b0);
         mode_in  = MODE_IDLE;
         win_in   = '0;
         rlen_in  = '0;
         sline_in = 16'd1;
         scol_in  = 16'd1;
         soff_in  = '0;
         cline_in = 16'd1;
         ccol_in  = 16'd1;
         coff_in  = '0;
      end

      // pack the candidates in order
      push_rec[0] = '0;
      push_rec[1] = '0;
      push_rec[2] = '0;
      n = 2'd0;
      if (ok_a) begin
         push_rec[0] = rec_a;
         n = 2'd1;
      end
      if (ok_b) begin
         case (n)
            2'd0:    push_rec[0] = rec_b;
            2'd1:    push_rec[1] = rec_b;
            default: push_rec[2] = rec_b;
         endcase
         n = n + 2'd1;
      end
      if (ok_c) begin
         case (n)
            2'd0:    push_rec[0] = rec_c;
            2'd1:    push_rec[1] = rec_c;
            default: push_rec[2] = rec_c;
         endcase
         n = n + 2'd1;
      end
      if (ok_d) begin
         case (n)
            2'd0:    push_rec[0] = rec_d;
            2'd1:    push_rec[1] = rec_d;
            default: push_rec[2] = rec_d;
         endcase
         n = n + 2'd1;
      end
      case (n)
         2'd1:    push_rec[0].last = 1'b1;
         2'd2:    push_rec[1].last = 1'b1;
         2'd3:    push_rec[2].last = 1'b1;
         default: ;
      endcase
      push_count = n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         win_ff   <= '0;
         rlen_ff  <= '0;
         sline_ff <= 16'd1;
         scol_ff  <= 16'd1;
         soff_ff  <= '0;
         cline_ff <= 16'd1;
         ccol_ff  <= 16'd1;
         coff_ff  <= '0;
      end else if (accept) begin
         mode_ff  <= mode_in;
         win_ff   <= win_in;
         rlen_ff  <= rlen_in;
         sline_ff <= sline_in;
         scol_ff  <= scol_in;
         soff_ff  <= soff_in;
         cline_ff <= cline_in;
         ccol_ff  <= ccol_in;
         coff_ff  <= coff_in;
      end
   end

endmodule

// ===== src/ktl_rsp_queue.sv =====
module ktl_rsp_queue import ktl_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic [1:0]    push_count,
   input  token_rec_type push_rec [MAX_RESULTS],
   input  logic          out_ready,
   output logic          out_valid,
   output token_rec_type out_rec,
   output logic [2:0]    level
);

   token_rec_type slot_ff [QUEUE_DEPTH];
   token_rec_type slot_in [QUEUE_DEPTH];
   logic [2:0]    count_ff, count_in;
   logic [2:0]    base_count;
   logic          pop;

   assign out_valid = count_ff != 3'd0;
   assign out_rec   = slot_ff[0];
   assign level     = count_ff;
   assign pop       = out_valid && out_ready;

   always_comb begin
      base_count = count_ff - {2'd0, pop};
      for (int j = 0; j < QUEUE_DEPTH; j++) begin
         // head leaves by shifting everything down one place
         slot_in[j] = pop ? slot_ff[(j + 1 < QUEUE_DEPTH) ? j + 1 : j] : slot_ff[j];
         for (int i = 0; i < MAX_RESULTS; i++) begin
            if (2'(i) < push_count && base_count + 3'(i) == 3'(j)) begin
               slot_in[j] = push_rec[i];
            end
         end
      end
      count_in = base_count + {1'b0, push_count};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < QUEUE_DEPTH; j++) begin
         slot_ff[j] <= slot_in[j];
      end
   end

endmodule

// ===== src/keyword_token_lexer_core.sv =====
// tokens: a byte's tokens enter the result queue at its transaction and are offered in order
// throughput: one byte per cycle while each byte gives at most one token and the output drains;
// a byte giving two or three tokens holds the input until the four-entry result queue has
// at most one token left, the queue depth less the three results one byte can give
// reset: synchronous, clears scan state, line/column/offset counters and the result queue
module keyword_token_lexer_core import ktl_pkg::*; #(
   parameter int TEXT_BUFFER_SIZE = DEFAULT_TEXT_BUFFER_SIZE
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // text_byte
   input  logic        req_tlast,   // final_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // token_line, token_column, token_offset, token_length
   output logic [5:0]  rsp_tuser,   // token_kind, text_dropped
   output logic        rsp_tlast    // run_last
);

   logic          accept;
   logic [1:0]    scan_count;
   logic [1:0]    push_count;
   token_rec_type scan_rec [MAX_RESULTS];
   token_rec_type head_rec;
   logic [2:0]    level;

   // room for a full burst of results from one byte
   assign req_tready = level <= 3'(QUEUE_DEPTH - MAX_RESULTS);
   assign accept     = req_tvalid && req_tready;
   assign push_count = accept ? scan_count : 2'd0;

   ktl_scan #(
      .TEXT_BUFFER_SIZE(TEXT_BUFFER_SIZE)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .text_byte  (req_tdata),
      .final_byte (req_tlast),
      .push_count (scan_count),
      .push_rec   (scan_rec)
   );

   ktl_rsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push_rec   (scan_rec),
      .out_ready  (rsp_tready),
      .out_valid  (rsp_tvalid),
      .out_rec    (head_rec),
      .level      (level)
   );

   assign rsp_tdata = {head_rec.length, head_rec.offset, head_rec.column, head_rec.line};
   assign rsp_tuser = {head_rec.dropped, head_rec.kind};
   assign rsp_tlast = head_rec.last;

endmodule

// ===== bench/tb_keyword_token_lexer_core.sv =====
`timescale 1ns / 1ps

module tb_keyword_token_lexer_core;
   import ktl_pkg::*;

   localparam int BUFFER_SIZE = DEFAULT_TEXT_BUFFER_SIZE;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int PRINT_CAP   = 100;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // text_byte
   logic        req_tlast;   // final_byte
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [79:0] rsp_tdata;   // token_line, token_column, token_offset, token_length
   logic [5:0]  rsp_tuser;   // token_kind, text_dropped
   logic        rsp_tlast;   // run_last

   keyword_token_lexer_core #(
      .TEXT_BUFFER_SIZE(BUFFER_SIZE)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   class token_tracker;
      mode_type      mode;
      logic [63:0]   window;
      logic [15:0]   run_len;
      logic [15:0]   start_line, start_col, cur_line, cur_col;
      logic [31:0]   start_off, cur_off;
      token_rec_type awaited[$];
      token_rec_type staged[$];
      string         keyword_words[KEYWORD_COUNT];
      int            errors;

      function new();
         keyword_words = '{"zone", "mem", "emit", "split", "move", "store", "retrieve",
                           "cycle", "fuse", "on", "empty", "not", "if", "every", "ms", "all"};
         errors = 0;
         restart();
      endfunction

      function void restart();
         mode       = MODE_IDLE;
         window     = '0;
         run_len    = '0;
         start_line = 16'd1;
         start_col  = 16'd1;
         start_off  = '0;
         cur_line   = 16'd1;
         cur_col    = 16'd1;
         cur_off    = '0;
      endfunction

      function logic [15:0] inc16(logic [15:0] v);
         return (v == 16'hFFFF) ? v : v + 16'd1;
      endfunction

      function bit is_digit(logic [7:0] b);
         return b >= "0" && b <= "9";
      endfunction

      function bit is_word_char(logic [7:0] b);
         return is_digit(b) || (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
      endfunction

      function bit is_space(logic [7:0] b);
         return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
      endfunction

      function logic [4:0] single_kind(logic [7:0] b);
         case (b)
            "(": return KIND_LPAREN;
            ")": return KIND_RPAREN;
            ";": return KIND_SEMI;
            ",": return KIND_COMMA;
            "+": return KIND_PLUS;
            "%": return KIND_PERCENT;
            ".": return KIND_DOT;
            default: return KIND_UNKNOWN;
         endcase
      endfunction

      function void stage(logic [4:0] kind, logic [15:0] line, logic [15:0] col,
                          logic [31:0] off, logic [15:0] len, logic drop);
         token_rec_type t;
         t.kind    = kind;
         t.line    = line;
         t.column  = col;
         t.offset  = off;
         t.length  = len;
         t.dropped = drop;
         t.last    = 1'b0;
         staged.push_back(t);
      endfunction

      function void open_run(mode_type m);
         mode       = m;
         start_line = cur_line;
         start_col  = cur_col;
         start_off  = cur_off;
         run_len    = '0;
         window     = '0;
      endfunction

      function void grow(logic [7:0] b);
         run_len = inc16(run_len);
         window  = {window[55:0], b};
      endfunction

      // window holds the last eight characters, so only an exact length can match
      function logic [4:0] word_kind();
         logic [63:0] word_bits;
         logic [63:0] mask;
         int          n;
         for (int i = 0; i < KEYWORD_COUNT; i++) begin
            n = keyword_words[i].len();
            word_bits = '0;
            for (int j = 0; j < n; j++)
               word_bits = {word_bits[55:0], 8'(keyword_words[i][j])};
            if (run_len == n) begin
               mask = (n >= 8) ? '1 : ((64'd1 << (8 * n)) - 64'd1);
               if ((window & mask) == word_bits)
                  return KIND_KEYWORD0 + 5'(i);
            end
         end
         return KIND_IDENT;
      endfunction

      function void close_run();
         logic drop;
         drop = (run_len >= BUFFER_SIZE);
         case (mode)
            MODE_MINUS, MODE_COLON:
               stage(KIND_UNKNOWN, start_line, start_col, start_off, 16'd1, 1'b0);
            MODE_MEMREF:
               stage(KIND_MEMREF, start_line, start_col, start_off, run_len, drop);
            MODE_NUMBER:
               stage(KIND_NUMBER, start_line, start_col, start_off, run_len, drop);
            MODE_IDENT:
               stage(drop ? KIND_IDENT : word_kind(), start_line, start_col, start_off,
                     run_len, drop);
            default: ;
         endcase
         mode    = MODE_IDLE;
         run_len = '0;
         window  = '0;
      endfunction

      function void take_byte(logic [7:0] b, logic last_byte);
         logic       used;
         logic [7:0] want;
         logic [4:0] sk;
         staged.delete();
         used = 1'b0;
         case (mode)
            MODE_MINUS, MODE_COLON: begin
               want = (mode == MODE_MINUS) ? ">" : "=";
               if (b == want) begin
                  stage((mode == MODE_MINUS) ? KIND_ARROW : KIND_ASSIGN, start_line,
                        start_col, start_off, 16'd2, 1'b0);
                  mode = MODE_IDLE;
                  used = 1'b1;
               end else begin
                  close_run();
               end
            end
            MODE_MEMREF, MODE_IDENT: begin
               if (is_word_char(b)) begin
                  grow(b);
                  used = 1'b1;
               end else begin
                  close_run();
               end
            end
            MODE_NUMBER: begin
               if (is_digit(b)) begin
                  grow(b);
                  used = 1'b1;
               end else begin
                  close_run();
               end
            end
            default: ;
         endcase

         if (!used && !is_space(b)) begin
            sk = single_kind(b);
            if (sk != KIND_UNKNOWN) begin
               stage(sk, cur_line, cur_col, cur_off, 16'd1, 1'b0);
            end else if (b == "-") begin
               open_run(MODE_MINUS);
            end else if (b == ":") begin
               open_run(MODE_COLON);
            end else if (b == "#") begin
               open_run(MODE_MEMREF);
               run_len = 16'd1;
            end else if (is_digit(b)) begin
               open_run(MODE_NUMBER);
               grow(b);
            end else if (is_word_char(b)) begin
               open_run(MODE_IDENT);
               grow(b);
            end else begin
               stage(KIND_UNKNOWN, cur_line, cur_col, cur_off, 16'd1, 1'b0);
            end
         end

         if (b == 8'h0A) begin
            cur_line = inc16(cur_line);
            cur_col  = 16'd1;
         end else begin
            cur_col = inc16(cur_col);
         end
         cur_off = (cur_off == '1) ? cur_off : cur_off + 32'd1;

         if (last_byte) begin
            close_run();
            stage(KIND_EOF, cur_line, cur_col, cur_off, 16'd0, 1'b0);
            restart();
         end

         foreach (staged[i]) begin
            staged[i].last = (i == staged.size() - 1);
            awaited.push_back(staged[i]);
         end
      endfunction

      task report(string msg);
         errors++;
         if (errors <= PRINT_CAP)
            $display("mismatch at %0t: %s", $realtime, msg);
      endtask

      task check_field(string name, longint got, longint want, logic [31:0] at);
         if (got != want)
            report($sformatf("token at offset %0d: %s is %0d, expected %0d",
                             at, name, got, want));
      endtask

      task match_token(token_rec_type got);
         token_rec_type want;
         if (awaited.size() == 0) begin
            report($sformatf("token kind %0d at offset %0d with nothing pending",
                             got.kind, got.offset));
            return;
         end
         want = awaited.pop_front();
         check_field("kind",    got.kind,    want.kind,    want.offset);
         check_field("line",    got.line,    want.line,    want.offset);
         check_field("column",  got.column,  want.column,  want.offset);
         check_field("offset",  got.offset,  want.offset,  want.offset);
         check_field("length",  got.length,  want.length,  want.offset);
         check_field("dropped", got.dropped, want.dropped, want.offset);
         check_field("last",    got.last,    want.last,    want.offset);
      endtask
   endclass

   token_tracker tracker;
   logic [7:0]   text_buf[$];
   bit           gapless;
   int           cycles;

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin : watch_tokens
      token_rec_type got;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         got.kind    = rsp_tuser[4:0];
         got.dropped = rsp_tuser[5];
         got.line    = rsp_tdata[15:0];
         got.column  = rsp_tdata[31:16];
         got.offset  = rsp_tdata[63:32];
         got.length  = rsp_tdata[79:64];
         got.last    = rsp_tlast;
         tracker.match_token(got);
      end
   end

   // token sink with random back-pressure
   initial begin : drain_tokens
      int stall;
      rsp_tready = 1'b0;
      forever begin
         stall = gapless ? 0 : $urandom_range(0, 6);
         repeat (stall) begin
            @(negedge clock);
            rsp_tready <= 1'b0;
         end
         @(negedge clock);
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid === 1'b1 && rsp_tready));
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic last_byte);
      int gap;
      gap = gapless ? 0 : $urandom_range(0, 6);
      repeat (gap) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last_byte;
      do @(posedge clock); while (req_tready !== 1'b1);
      tracker.take_byte(b, last_byte);
   endtask

   task automatic send_text(input bit end_text);
      foreach (text_buf[i])
         send_byte(text_buf[i], end_text && (i == text_buf.size() - 1));
      text_buf.delete();
   endtask

   function automatic void add_str(string s);
      for (int i = 0; i < s.len(); i++)
         text_buf.push_back(8'(s[i]));
   endfunction

   function automatic logic [7:0] ident_start();
      int r;
      r = $urandom_range(0, 52);
      if (r < 26) return 8'("a" + r);
      if (r < 52) return 8'("A" + r - 26);
      return "_";
   endfunction

   function automatic logic [7:0] word_char();
      int r;
      r = $urandom_range(0, 62);
      if (r < 26) return 8'("a" + r);
      if (r < 52) return 8'("A" + r - 26);
      if (r < 62) return 8'("0" + r - 52);
      return "_";
   endfunction

   function automatic logic [7:0] space_char();
      int r;
      r = $urandom_range(8, 13);
      return (r == 8) ? 8'h20 : 8'(r);
   endfunction

   // runs around the buffer size hit both sides of the dropped-text threshold
   function automatic void add_long_run();
      int len;
      int pick;
      len  = $urandom_range(BUFFER_SIZE - 4, BUFFER_SIZE + 6);
      pick = $urandom_range(0, 2);
      if (pick == 0) begin
         text_buf.push_back(ident_start());
         repeat (len - 1) text_buf.push_back(word_char());
      end else if (pick == 1) begin
         repeat (len) text_buf.push_back(8'("0" + $urandom_range(0, 9)));
      end else begin
         text_buf.push_back("#");
         repeat (len - 1) text_buf.push_back(word_char());
      end
   endfunction

   function automatic void add_random_piece();
      int    pick;
      int    n;
      string w;
      string singles;
      singles = "();,+%.";
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
         w = tracker.keyword_words[$urandom_range(0, KEYWORD_COUNT - 1)];
         n = $urandom_range(0, 9);
         if (n == 0)
            w = w.substr(0, w.len() - 2);
         else if (n == 1)
            w = {w, "s"};
         add_str(w);
      end else if (pick < 40) begin
         text_buf.push_back(ident_start());
         repeat ($urandom_range(0, 9)) text_buf.push_back(word_char());
      end else if (pick < 50) begin
         repeat ($urandom_range(1, 6)) text_buf.push_back(8'("0" + $urandom_range(0, 9)));
      end else if (pick < 58) begin
         text_buf.push_back("#");
         repeat ($urandom_range(0, 6)) text_buf.push_back(word_char());
      end else if (pick < 68) begin
         text_buf.push_back(8'(singles[$urandom_range(0, 6)]));
      end else if (pick < 74) begin
         add_str($urandom_range(0, 1) ? "->" : ":=");
      end else if (pick < 78) begin
         text_buf.push_back($urandom_range(0, 1) ? "-" : ":");
      end else if (pick < 83) begin
         text_buf.push_back(8'($urandom_range(0, 255)));
      end else if (pick < 86) begin
         add_long_run();
      end else begin
         repeat ($urandom_range(1, 3)) text_buf.push_back(space_char());
      end
   endfunction

   initial begin : stimulus
      int random_bytes;
      int pieces;
      clock      = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      gapless    = 1'b0;
      cycles     = 0;
      tracker    = new();

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // operators, lone minus and colon, nul and high bytes, newline, three tokens from one byte
      add_str("if(x)->#m :=4;a,+%.-q:r");
      text_buf.push_back(8'h00);
      text_buf.push_back(8'hFF);
      text_buf.push_back(8'h0A);
      add_str("ms-(");
      send_text(1'b1);

      random_bytes = 0;
      while (random_bytes < 160) begin
         gapless = ($urandom_range(0, 3) == 0);
         pieces  = $urandom_range(3, 20);
         for (int p = 0; p < pieces; p++) begin
            add_random_piece();
            if (p < pieces - 1 && $urandom_range(0, 9) < 7)
               text_buf.push_back(space_char());
         end
         random_bytes += text_buf.size();
         send_text(1'b1);
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      gapless = 1'b0;

      while (tracker.awaited.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (tracker.errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
